// File: src/sfm_pkg.sv
// ----------------------------------------------------------------------------
// sfm_pkg
// Shared types and constants for the sensor fault monitor.
// ----------------------------------------------------------------------------
package sfm_pkg;

    localparam int BATT_W = 12;
    localparam int WORD_W = 32;
    localparam int CNT_W  = 16;
    localparam int TICK_W = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [TICK_W-1:0] t_tick;
    typedef logic [WORD_W-1:0] t_word;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LV_THRESH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_PERIOD = 2'd1;

    localparam logic [BATT_W-1:0] LV_THRESH_RST   = 12'd1218;
    localparam t_tick             SLOW_PERIOD_RST = 6'd40;

    // trip levels, fault sets when count > trip
    localparam t_cnt BATT_TRIP  = 16'd99;
    localparam t_cnt BARO_TRIP  = 16'd5;
    localparam t_cnt ACCEL_TRIP = 16'd20;
    localparam t_cnt GYRO_TRIP  = 16'd20;
    localparam t_cnt MAG_TRIP   = 16'd10;
    localparam t_cnt CNT_MAX    = 16'hFFFF;

    typedef struct packed {
        logic en;   // update this tick
        logic hit;  // low sample or repeated words
    } t_chk_ctl;

endpackage

// File: src/sfm_stuck_chk.sv
// ----------------------------------------------------------------------------
// sfm_stuck_chk
// Saturating fault counter with set / halve-and-clear fault flag.
// ----------------------------------------------------------------------------
module sfm_stuck_chk (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sfm_pkg::t_chk_ctl i_ctl,
    input  sfm_pkg::t_cnt   i_trip,
    output logic            o_flag
);
    import sfm_pkg::*;

    t_cnt r_cnt, n_cnt;
    logic r_flag, n_flag;

    always_comb begin
        n_cnt  = r_cnt;
        n_flag = r_flag;
        if (i_ctl.en) begin
            if (i_ctl.hit) begin
                n_cnt = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + 1'b1;
                if (n_cnt > i_trip) begin
                    n_flag = 1'b1;
                end
            end else begin
                n_cnt = r_cnt >> 1;
                if (n_cnt == '0) begin
                    n_flag = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_flag <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_flag <= n_flag;
        end
    end

    assign o_flag = r_flag;

    // flag never set while the counter is zero
    a_flag_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flag |-> (r_cnt != '0))
        else $error("fault flag set with zero count");

endmodule

// File: src/sfm_slow_div.sv
// ----------------------------------------------------------------------------
// sfm_slow_div
// Tick divider that marks every n-th tick for the slow sensor checks.
// ----------------------------------------------------------------------------
module sfm_slow_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  sfm_pkg::t_tick i_period,
    output logic          o_due
);
    import sfm_pkg::*;

    t_tick r_tick, n_tick;
    t_tick w_inc;

    assign w_inc = r_tick + 1'b1;
    // a period of zero behaves like one
    assign o_due = (w_inc >= i_period);

    always_comb begin
        n_tick = r_tick;
        if (i_en) begin
            n_tick = o_due ? '0 : w_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
        end else begin
            r_tick <= n_tick;
        end
    end

endmodule

// File: src/sensor_fault_monitor.sv
// ----------------------------------------------------------------------------
// sensor_fault_monitor
// Battery low-voltage and stuck-sensor monitor, one result beat per tick.
// ----------------------------------------------------------------------------
// throughput: one tick per cycle while the result is not stalled; input register feeds the counter update,
//   whose fault flag registers are the result register
// reset: synchronous active low; counters, dividers, previous words and flags
//   clear, registers return to threshold 1218 and period 40
module sensor_fault_monitor (
    input  logic i_clk,
    input  logic i_rst_n,

    input  logic i_cfg_we,
    input  logic [sfm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sfm_pkg::CFG_DATA_W-1:0] i_cfg_data,

    input  logic i_in_valid,
    output logic o_in_stall,
    input  logic [sfm_pkg::BATT_W-1:0] i_battery_sample,
    input  sfm_pkg::t_word i_baro_word,
    input  sfm_pkg::t_word i_accel_x,
    input  sfm_pkg::t_word i_accel_y,
    input  sfm_pkg::t_word i_accel_z,
    input  sfm_pkg::t_word i_gyro_x,
    input  sfm_pkg::t_word i_gyro_y,
    input  sfm_pkg::t_word i_gyro_z,
    input  sfm_pkg::t_word i_mag_x,
    input  sfm_pkg::t_word i_mag_y,
    input  sfm_pkg::t_word i_mag_z,

    output logic o_out_valid,
    input  logic i_out_stall,
    output logic o_low_voltage_fault,
    output logic o_baro_fault,
    output logic o_accel_fault,
    output logic o_gyro_fault,
    output logic o_mag_fault
);
    import sfm_pkg::*;

    logic [BATT_W-1:0] r_lv_thresh;
    t_tick             r_slow_period;

    // input register
    logic              r_in_valid;
    logic [BATT_W-1:0] r_batt;
    t_word             r_baro;
    t_word             r_acc [3];
    t_word             r_gyr [3];
    t_word             r_mag [3];

    // previous words
    t_word r_prev_baro;
    t_word r_prev_acc [3];
    t_word r_prev_gyr [3];
    t_word r_prev_mag [3];

    logic r_out_valid;
    logic w_adv, w_upd;
    logic w_baro_due, w_mag_due;
    t_chk_ctl w_batt_ctl, w_baro_ctl, w_acc_ctl, w_gyr_ctl, w_mag_ctl;

    assign w_adv      = !r_out_valid || !i_out_stall;
    assign w_upd      = r_in_valid && w_adv;
    assign o_in_stall = r_in_valid && !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lv_thresh   <= LV_THRESH_RST;
            r_slow_period <= SLOW_PERIOD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LV_THRESH:   r_lv_thresh   <= i_cfg_data;
                CFG_SLOW_PERIOD: r_slow_period <= i_cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_batt   <= i_battery_sample;
            r_baro   <= i_baro_word;
            r_acc[0] <= i_accel_x;
            r_acc[1] <= i_accel_y;
            r_acc[2] <= i_accel_z;
            r_gyr[0] <= i_gyro_x;
            r_gyr[1] <= i_gyro_y;
            r_gyr[2] <= i_gyro_z;
            r_mag[0] <= i_mag_x;
            r_mag[1] <= i_mag_y;
            r_mag[2] <= i_mag_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_baro <= '0;
            for (int k = 0; k < 3; k++) begin
                r_prev_acc[k] <= '0;
                r_prev_gyr[k] <= '0;
                r_prev_mag[k] <= '0;
            end
        end else if (w_upd) begin
            for (int k = 0; k < 3; k++) begin
                r_prev_acc[k] <= r_acc[k];
                r_prev_gyr[k] <= r_gyr[k];
            end
            if (w_baro_due) begin
                r_prev_baro <= r_baro;
            end
            if (w_mag_due) begin
                for (int k = 0; k < 3; k++) begin
                    r_prev_mag[k] <= r_mag[k];
                end
            end
        end
    end

    sfm_slow_div u_baro_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_upd),
        .i_period (r_slow_period),
        .o_due    (w_baro_due)
    );

    sfm_slow_div u_mag_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_upd),
        .i_period (r_slow_period),
        .o_due    (w_mag_due)
    );

    always_comb begin
        w_batt_ctl.en  = w_upd;
        w_batt_ctl.hit = (r_batt < r_lv_thresh);
        w_baro_ctl.en  = w_upd && w_baro_due;
        w_baro_ctl.hit = (r_baro == r_prev_baro);
        w_acc_ctl.en   = w_upd;
        w_acc_ctl.hit  = (r_acc[0] == r_prev_acc[0]) && (r_acc[1] == r_prev_acc[1]) &&
                         (r_acc[2] == r_prev_acc[2]);
        w_gyr_ctl.en   = w_upd;
        w_gyr_ctl.hit  = (r_gyr[0] == r_prev_gyr[0]) && (r_gyr[1] == r_prev_gyr[1]) &&
                         (r_gyr[2] == r_prev_gyr[2]);
        w_mag_ctl.en   = w_upd && w_mag_due;
        w_mag_ctl.hit  = (r_mag[0] == r_prev_mag[0]) && (r_mag[1] == r_prev_mag[1]) &&
                         (r_mag[2] == r_prev_mag[2]);
    end

    sfm_stuck_chk u_batt_chk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_batt_ctl),
        .i_trip  (BATT_TRIP),
        .o_flag  (o_low_voltage_fault)
    );

    sfm_stuck_chk u_baro_chk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_baro_ctl),
        .i_trip  (BARO_TRIP),
        .o_flag  (o_baro_fault)
    );

    sfm_stuck_chk u_acc_chk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_acc_ctl),
        .i_trip  (ACCEL_TRIP),
        .o_flag  (o_accel_fault)
    );

    sfm_stuck_chk u_gyr_chk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_gyr_ctl),
        .i_trip  (GYRO_TRIP),
        .o_flag  (o_gyro_fault)
    );

    sfm_stuck_chk u_mag_chk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mag_ctl),
        .i_trip  (MAG_TRIP),
        .o_flag  (o_mag_fault)
    );

    assign o_out_valid = r_out_valid;

    // a tick in the input register always yields a result beat
    a_tick_to_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_upd |=> r_out_valid)
        else $error("tick lost between input and result register");

    // flags only move on a tick update
    a_flags_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable({o_low_voltage_fault, o_accel_fault, o_gyro_fault}))
        |-> $past(w_upd))
        else $error("fault flag changed without a tick");

    // slow sensor flags only move on a check tick
    a_baro_slow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(o_baro_fault)) |-> $past(w_upd && w_baro_due))
        else $error("baro fault changed off a check tick");

    a_mag_slow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(o_mag_fault)) |-> $past(w_upd && w_mag_due))
        else $error("compass fault changed off a check tick");

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sensor_fault_monitor. Ticks are sent over the
// valid/stall input channel. A scoreboard predicts the five fault flags of
// every tick and compares them with the result beats in order. Run phases
// cover the default registers, long stuck runs past every trip level with a
// zero period, the threshold and period extremes, and random settings with
// stuck-sensor runs.
// ----------------------------------------------------------------------------
module tb;
    import sfm_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_TICKS     = 120;
    localparam int RAND_TICKS     = 70;
    localparam int RAND_PHASES    = 3;

    // indexes that map to no register
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam t_cnt LOWV_SET_COUNT   = 16'd100;
    localparam t_cnt BARO_STUCK_TRIP  = 16'd5;
    localparam t_cnt ACCEL_STUCK_TRIP = 16'd20;
    localparam t_cnt GYRO_STUCK_TRIP  = 16'd20;
    localparam t_cnt MAG_STUCK_TRIP   = 16'd10;
    localparam t_cnt COUNT_CEIL       = 16'hFFFF;

    typedef enum int {GRP_BATT, GRP_BARO, GRP_ACCEL, GRP_GYRO, GRP_MAG, GRP_COUNT} t_grp;

    typedef struct {
        logic [BATT_W-1:0] battery;
        t_word             baro;
        t_word             accel [3];
        t_word             gyro [3];
        t_word             mag [3];
    } t_tick_in;

    typedef struct packed {
        logic lowv;
        logic baro;
        logic accel;
        logic gyro;
        logic mag;
    } t_faults;

    class t_fault_scoreboard;
        logic [BATT_W-1:0] lv_thresh;
        t_tick             slow_period;
        t_cnt              batt_cnt, baro_cnt, accel_cnt, gyro_cnt, mag_cnt;
        t_tick             baro_div, mag_div;
        t_word             held_baro;
        t_word             held_accel [3];
        t_word             held_gyro [3];
        t_word             held_mag [3];
        t_faults           flags;
        t_faults           expected_faults [$];
        int                errors;
        int                results_seen;
        int                set_seen [GRP_COUNT];

        function void reset_state();
            lv_thresh   = 12'd1218;
            slow_period = 6'd40;
            batt_cnt    = '0;
            baro_cnt    = '0;
            accel_cnt   = '0;
            gyro_cnt    = '0;
            mag_cnt     = '0;
            baro_div    = '0;
            mag_div     = '0;
            held_baro   = '0;
            for (int k = 0; k < 3; k++) begin
                held_accel[k] = '0;
                held_gyro[k]  = '0;
                held_mag[k]   = '0;
            end
            flags = '0;
            expected_faults.delete();
            errors       = 0;
            results_seen = 0;
            for (int g = 0; g < GRP_COUNT; g++) set_seen[g] = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_LV_THRESH:   lv_thresh = data[BATT_W-1:0];
                CFG_SLOW_PERIOD: slow_period = data[TICK_W-1:0];
                default: ;
            endcase
        endfunction

        function t_cnt bump(t_cnt c);
            return (c == COUNT_CEIL) ? c : c + 1'b1;
        endfunction

        // a zero period makes every tick a check tick
        function bit slow_due(inout t_tick div);
            t_tick nxt;
            nxt = div + 1'b1;
            if (nxt >= slow_period) begin
                div = '0;
                return 1'b1;
            end
            div = nxt;
            return 1'b0;
        endfunction

        function void stuck_step(inout t_cnt cnt, inout logic flag, input bit same,
                                 input t_cnt trip);
            if (same) begin
                cnt = bump(cnt);
                if (cnt > trip) flag = 1'b1;
            end else begin
                cnt = cnt >> 1;
                if (cnt == '0) flag = 1'b0;
            end
        endfunction

        function bit same3(t_word a [3], t_word b [3]);
            return a[0] == b[0] && a[1] == b[1] && a[2] == b[2];
        endfunction

        function void note_tick(t_tick_in t);
            if (t.battery < lv_thresh) begin
                batt_cnt = bump(batt_cnt);
                if (batt_cnt >= LOWV_SET_COUNT) flags.lowv = 1'b1;
            end else begin
                batt_cnt = batt_cnt >> 1;
                if (batt_cnt == '0) flags.lowv = 1'b0;
            end
            if (slow_due(baro_div)) begin
                stuck_step(baro_cnt, flags.baro, held_baro == t.baro, BARO_STUCK_TRIP);
                held_baro = t.baro;
            end
            stuck_step(accel_cnt, flags.accel, same3(held_accel, t.accel), ACCEL_STUCK_TRIP);
            held_accel = t.accel;
            stuck_step(gyro_cnt, flags.gyro, same3(held_gyro, t.gyro), GYRO_STUCK_TRIP);
            held_gyro = t.gyro;
            if (slow_due(mag_div)) begin
                stuck_step(mag_cnt, flags.mag, same3(held_mag, t.mag), MAG_STUCK_TRIP);
                held_mag = t.mag;
            end
            expected_faults.push_back(flags);
        endfunction

        function void check_bit(string name, logic exp, logic got);
            if (got !== exp) begin
                $error("%s: expected %0b, got %0b", name, exp, got);
                errors++;
            end
        endfunction

        function void check_faults(t_faults got);
            t_faults exp;
            if (expected_faults.size() == 0) begin
                $error("result beat with no tick outstanding");
                errors++;
                return;
            end
            exp = expected_faults.pop_front();
            check_bit("low_voltage_fault", exp.lowv, got.lowv);
            check_bit("baro_fault", exp.baro, got.baro);
            check_bit("accel_fault", exp.accel, got.accel);
            check_bit("gyro_fault", exp.gyro, got.gyro);
            check_bit("mag_fault", exp.mag, got.mag);
            results_seen++;
            set_seen[GRP_BATT]  += exp.lowv;
            set_seen[GRP_BARO]  += exp.baro;
            set_seen[GRP_ACCEL] += exp.accel;
            set_seen[GRP_GYRO]  += exp.gyro;
            set_seen[GRP_MAG]   += exp.mag;
        endfunction

        function int pending();
            return expected_faults.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic i_in_valid;
    logic o_in_stall;
    logic [BATT_W-1:0] i_battery_sample;
    t_word i_baro_word;
    t_word i_accel_x, i_accel_y, i_accel_z;
    t_word i_gyro_x, i_gyro_y, i_gyro_z;
    t_word i_mag_x, i_mag_y, i_mag_z;
    logic o_out_valid;
    logic i_out_stall;
    logic o_low_voltage_fault, o_baro_fault, o_accel_fault, o_gyro_fault, o_mag_fault;

    t_fault_scoreboard sb;
    t_tick_in drv_tick;
    t_tick_in last_sent;
    bit    tx_gaps_on;
    bit    rx_gaps_on;
    int    rx_wait = 0;
    int    idle_cycles = 0;

    always #1 i_clk = ~i_clk;

    assign i_battery_sample = drv_tick.battery;
    assign i_baro_word      = drv_tick.baro;
    assign i_accel_x        = drv_tick.accel[0];
    assign i_accel_y        = drv_tick.accel[1];
    assign i_accel_z        = drv_tick.accel[2];
    assign i_gyro_x         = drv_tick.gyro[0];
    assign i_gyro_y         = drv_tick.gyro[1];
    assign i_gyro_z         = drv_tick.gyro[2];
    assign i_mag_x          = drv_tick.mag[0];
    assign i_mag_y          = drv_tick.mag[1];
    assign i_mag_z          = drv_tick.mag[2];

    sensor_fault_monitor dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_battery_sample    (i_battery_sample),
        .i_baro_word         (i_baro_word),
        .i_accel_x           (i_accel_x),
        .i_accel_y           (i_accel_y),
        .i_accel_z           (i_accel_z),
        .i_gyro_x            (i_gyro_x),
        .i_gyro_y            (i_gyro_y),
        .i_gyro_z            (i_gyro_z),
        .i_mag_x             (i_mag_x),
        .i_mag_y             (i_mag_y),
        .i_mag_z             (i_mag_z),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_low_voltage_fault (o_low_voltage_fault),
        .o_baro_fault        (o_baro_fault),
        .o_accel_fault       (o_accel_fault),
        .o_gyro_fault        (o_gyro_fault),
        .o_mag_fault         (o_mag_fault)
    );

    function automatic int draw_wait(bit gaps_on);
        if (!gaps_on || $urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, 17);
    endfunction

    function automatic t_word fresh_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_tick_in make_tick(logic [BATT_W-1:0] batt, t_word w);
        t_tick_in t;
        t.battery = batt;
        t.baro    = w;
        for (int k = 0; k < 3; k++) begin
            t.accel[k] = w;
            t.gyro[k]  = w;
            t.mag[k]   = w;
        end
        return t;
    endfunction

    // a held sensor sometimes gets a single flipped bit to break the run
    function automatic void update_word(inout t_word w, input bit hold);
        if (!hold) w = fresh_word();
        else if ($urandom_range(0, 15) == 0) w ^= 32'd1 << $urandom_range(0, 31);
    endfunction

    function automatic void update_axes(inout t_word w [3], input bit hold);
        int k;
        if (!hold) begin
            for (k = 0; k < 3; k++) w[k] = fresh_word();
        end else if ($urandom_range(0, 15) == 0) begin
            k = $urandom_range(0, 2);
            w[k] ^= 32'd1 << $urandom_range(0, 31);
        end
    endfunction

    function automatic logic [BATT_W-1:0] pick_battery(bit low);
        int thr;
        thr = sb.lv_thresh;
        if ($urandom_range(0, 15) == 0) return $urandom_range(0, 1) ? '1 : '0;
        if (low && thr > 0) return BATT_W'($urandom_range(0, thr - 1));
        return BATT_W'($urandom_range(thr, 4095));
    endfunction

    function automatic int run_length(int g, bit hold);
        int per;
        per = (sb.slow_period == 0) ? 1 : sb.slow_period;
        if (!hold) return $urandom_range(1, 6);
        case (g)
            GRP_BATT: return $urandom_range(0, 1) ? $urandom_range(95, 140)
                                                  : $urandom_range(1, 30);
            GRP_BARO, GRP_MAG: return $urandom_range(1, 14 * per + 2);
            default: return $urandom_range(1, 40);
        endcase
    endfunction

    // sample both channels at the rising edge, inputs are noted before results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) sb.note_tick(drv_tick);
            if (o_out_valid && !i_out_stall) begin
                sb.check_faults(t_faults'({o_low_voltage_fault, o_baro_fault, o_accel_fault,
                                           o_gyro_fault, o_mag_fault}));
                rx_wait = draw_wait(rx_gaps_on);
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= rx_gaps_on && rx_wait > 0;
        if (rx_wait > 0) rx_wait = rx_wait - 1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // entered and left at a falling edge
    task automatic send_tick(input t_tick_in t);
        int gap;
        gap = draw_wait(tx_gaps_on);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        drv_tick   <= t;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic finish_phase();
        i_in_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic run_directed();
        t_tick_in t;
        int i;
        // zero words match the cleared previous words
        t = make_tick(12'd0, '0);
        send_tick(t);
        t = make_tick(12'hFFF, '1);
        send_tick(t);
        t.battery = 12'd1217;   // one below the default threshold
        send_tick(t);
        t.battery = 12'd1218;
        send_tick(t);
        t = make_tick(12'd1219, 32'h8000_0000);
        send_tick(t);
        t = make_tick(12'd1, 32'h0000_0001);
        send_tick(t);
        // one axis differs, the rest repeat
        t.battery = 12'd4094;
        t.accel[0] ^= 32'h8000_0000;
        send_tick(t);
        t.gyro[2] ^= 32'h0000_0001;
        send_tick(t);
        t = make_tick(12'd0, 32'h7FFF_FFFF);
        for (i = 0; i < 16; i++) begin
            t.battery = i[0] ? 12'd1218 : 12'd0;
            send_tick(t);
        end
        last_sent = t;
    endtask

    // hold every sensor stuck well past its trip level, then let the flags decay
    task automatic run_stuck_hold();
        t_tick_in t;
        int i;
        t = last_sent;
        t.battery = '0;
        for (i = 0; i < HOLD_TICKS; i++) send_tick(t);
        for (i = 0; i < 20; i++) begin
            t.battery = '1;
            t.baro    = ~t.baro;
            for (int k = 0; k < 3; k++) begin
                t.accel[k] = ~t.accel[k];
                t.gyro[k]  = ~t.gyro[k];
                t.mag[k]   = ~t.mag[k];
            end
            send_tick(t);
        end
        last_sent = t;
    endtask

    task automatic run_random(input int n);
        t_tick_in t;
        int run_left [GRP_COUNT];
        bit hold [GRP_COUNT];
        int i;
        int g;
        t = last_sent;
        for (g = 0; g < GRP_COUNT; g++) run_left[g] = 0;
        for (i = 0; i < n; i++) begin
            for (g = 0; g < GRP_COUNT; g++) begin
                if (run_left[g] == 0) begin
                    hold[g]     = 1'($urandom_range(0, 1));
                    run_left[g] = run_length(g, hold[g]);
                end
                run_left[g]--;
            end
            t.battery = pick_battery(hold[GRP_BATT]);
            update_word(t.baro, hold[GRP_BARO]);
            update_axes(t.accel, hold[GRP_ACCEL]);
            update_axes(t.gyro, hold[GRP_GYRO]);
            update_axes(t.mag, hold[GRP_MAG]);
            send_tick(t);
        end
        last_sent = t;
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_out_stall = 1'b0;
        drv_tick   = make_tick('0, '0);
        last_sent  = drv_tick;
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        run_directed();
        finish_phase();

        // max threshold, period field written with only upper data bits set
        write_cfg(CFG_LV_THRESH, 12'hFFF);
        write_cfg(CFG_SLOW_PERIOD, 12'hFC0);
        write_cfg(CFG_SPARE_A, CFG_DATA_W'($urandom));
        write_cfg(CFG_SPARE_B, CFG_DATA_W'($urandom));
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        run_stuck_hold();
        finish_phase();

        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        write_cfg(CFG_LV_THRESH, 12'd0);
        write_cfg(CFG_SLOW_PERIOD, 12'd63);
        run_random(RAND_TICKS);
        finish_phase();

        // period drops below where the dividers currently stand
        write_cfg(CFG_SLOW_PERIOD, 12'd2);
        write_cfg(CFG_LV_THRESH, 12'd2048);
        run_random(RAND_TICKS);
        finish_phase();

        for (int p = 0; p < RAND_PHASES; p++) begin
            write_cfg(CFG_LV_THRESH, CFG_DATA_W'($urandom_range(1, 4095)));
            write_cfg(CFG_SLOW_PERIOD, CFG_DATA_W'($urandom_range(1, 8)));
            tx_gaps_on = $urandom_range(0, 3) != 0;
            rx_gaps_on = $urandom_range(0, 3) != 0;
            run_random(RAND_TICKS);
            finish_phase();
        end

        repeat (8) @(posedge i_clk);
        $display("%0d ticks checked over default, long stuck, extreme and random settings",
                 sb.results_seen);
        $display("ticks with fault set: lowv %0d baro %0d accel %0d gyro %0d mag %0d",
                 sb.set_seen[GRP_BATT], sb.set_seen[GRP_BARO], sb.set_seen[GRP_ACCEL],
                 sb.set_seen[GRP_GYRO], sb.set_seen[GRP_MAG]);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
